// File: rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int OUT_WIDTH   = 32;
  localparam int OUT_FRAC    = 16;
  localparam int QUOT_BITS   = 34;

  localparam logic [OUT_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_WIDTH-1:0] SAT_NEG = 32'h8000_0000;
  localparam logic [OUT_WIDTH-1:0] SAT_U   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
  } req_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] center_x;
    logic signed [OUT_WIDTH-1:0] center_y;
    logic signed [OUT_WIDTH-1:0] center_z;
    logic        [OUT_WIDTH-1:0] radius_squared;
    logic                        degenerate;
  } res_t;

endpackage

// File: rtl/tcc_mul.sv
module tcc_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic signed [AW+BL:0]    lo_q;
  logic signed [AW+BH-1:0]  hi_q;
  logic signed [AW+BW-1:0]  p_q;

  // split multiplier operand, partial products then sum
  always_ff @(posedge clk_i) begin
    lo_q <= a_i * $signed({1'b0, b_i[BL-1:0]});
    hi_q <= a_i * $signed(b_i[BW-1:BL]);
    p_q  <= ((AW+BW)'(hi_q) <<< BL) + (AW+BW)'(lo_q);
  end

  assign p_o = p_q;

endmodule

// File: rtl/tcc_dly.sv
module tcc_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [N-1:0][W-1:0] sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
    end else begin
      sr_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// File: rtl/tcc_cell.sv
module tcc_cell #(
  parameter int RW = 64,
  parameter int DW = 16,
  parameter int QW = 35,
  parameter int SH = 0,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [TW-1:0] tag_i,
  output logic [RW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [RW-1:0] trial;
  logic          ge;

  assign trial = RW'(den_i) << SH;
  assign ge    = rem_i >= trial;

  // one restoring division step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_o <= '0;
      den_o <= '0;
      quo_o <= '0;
      tag_o <= '0;
    end else begin
      rem_o <= ge ? rem_i - trial : rem_i;
      den_o <= den_i;
      quo_o <= quo_i | (QW'(ge) << SH);
      tag_o <= tag_i;
    end
  end

endmodule

// File: rtl/tcc_div.sv
module tcc_div #(
  parameter int RW = 64,
  parameter int DW = 16,
  parameter int QB = 34,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [RW-1:0] x_i,
  input  logic [DW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic [QB:0]   q_o,
  output logic [TW-1:0] tag_o
);

  logic [QB+1:0][RW-1:0] rem_w;
  logic [QB+1:0][DW-1:0] den_w;
  logic [QB+1:0][QB:0]   quo_w;
  logic [QB+1:0][TW-1:0] tag_w;

  assign rem_w[0] = x_i;
  assign den_w[0] = d_i;
  assign quo_w[0] = '0;
  assign tag_w[0] = tag_i;

  // top cell flags overflow, the rest produce quotient bits msb first
  for (genvar k = 0; k <= QB; k++) begin : g_cell
    tcc_cell #(
      .RW (RW),
      .DW (DW),
      .QW (QB + 1),
      .SH (QB - k),
      .TW (TW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rem_i  (rem_w[k]),
      .den_i  (den_w[k]),
      .quo_i  (quo_w[k]),
      .tag_i  (tag_w[k]),
      .rem_o  (rem_w[k+1]),
      .den_o  (den_w[k+1]),
      .quo_o  (quo_w[k+1]),
      .tag_o  (tag_w[k+1])
    );
  end

  assign q_o   = quo_w[QB+1];
  assign tag_o = tag_w[QB+1];

endmodule

// File: rtl/triangle_circumcenter_3d.sv
// Circumcenter and squared circumradius of a 3-D triangle, Q2.14 vertices in,
// Q16.16 results out, rounded to nearest and saturated; collinear vertices give
// degenerate=1 with zero fields. One request is taken every cycle (busy_o stays
// low) and its result strobes on done_o; each request passes through the
// multiplier pipeline and the 35-cell divider chain that produces one quotient
// bit per cell. Results cannot be held off by the receiver.
module triangle_circumcenter_3d (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tcc_pkg::req_t req_i,
  output logic          done_o,
  output tcc_pkg::res_t res_o
);

  localparam int CW    = tcc_pkg::COORD_WIDTH;
  localparam int OW    = tcc_pkg::OUT_WIDTH;
  localparam int OF    = tcc_pkg::OUT_FRAC;
  localparam int QB    = tcc_pkg::QUOT_BITS;
  localparam int FRAC  = CW - 2;
  localparam int EW    = CW + 1;
  localparam int MW    = 2 * EW + 1;
  localparam int LW    = 2 * EW + 1;
  localparam int MMW   = 2 * MW + 1;
  localparam int UW    = MW + EW + 1;
  localparam int NW    = UW + LW + 2;
  localparam int CSH_N = (FRAC <= OF) ? OF - FRAC : 0;
  localparam int CSH_D = (FRAC > OF) ? FRAC - OF : 0;
  localparam int RSH_N = (2 * FRAC <= OF) ? OF - 2 * FRAC : 0;
  localparam int RSH_D = (2 * FRAC > OF) ? 2 * FRAC - OF : 0;
  localparam int XCW   = NW + CSH_N + 1;
  localparam int DCW   = MMW + 1 + CSH_D;
  localparam int RWC   = ((XCW > DCW + QB) ? XCW : DCW + QB) + 1;
  localparam int XRW   = 3 * LW + RSH_N + 1;
  localparam int DRW   = MMW + 2 + RSH_D;
  localparam int RWR   = ((XRW > DRW + QB) ? XRW : DRW + QB) + 1;
  localparam int LAT   = 49;

  logic [2:0][CW-1:0] va, vb, vc;

  assign va = {req_i.first_z, req_i.first_y, req_i.first_x};
  assign vb = {req_i.second_z, req_i.second_y, req_i.second_x};
  assign vc = {req_i.third_z, req_i.third_y, req_i.third_x};

  // edge vectors
  logic               vld0_q;
  logic [2:0][EW-1:0] e1_q, e2_q, e3_q;
  logic [2:0][CW-1:0] a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= EW'($signed(vb[i])) - EW'($signed(va[i]));
      e2_q[i] <= EW'($signed(vc[i])) - EW'($signed(va[i]));
      e3_q[i] <= EW'($signed(vc[i])) - EW'($signed(vb[i]));
    end
    a_q <= va;
  end

  // normal and squared edge lengths
  logic [2:0][2*EW-1:0] pa, pb, sq1, sq2, sq3;
  logic [2:0][MW-1:0]   m_q;
  logic [2:0][LW-1:0]   l_q;
  logic [2:0][EW-1:0]   e1_d, e2_d;

  for (genvar i = 0; i < 3; i++) begin : g_mul_a
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    tcc_mul #(.AW(EW), .BW(EW)) u_pa (.clk_i(clk_i), .a_i(e1_q[J]), .b_i(e2_q[K]), .p_o(pa[i]));
    tcc_mul #(.AW(EW), .BW(EW)) u_pb (.clk_i(clk_i), .a_i(e1_q[K]), .b_i(e2_q[J]), .p_o(pb[i]));
    tcc_mul #(.AW(EW), .BW(EW)) u_s1 (.clk_i(clk_i), .a_i(e1_q[i]), .b_i(e1_q[i]), .p_o(sq1[i]));
    tcc_mul #(.AW(EW), .BW(EW)) u_s2 (.clk_i(clk_i), .a_i(e2_q[i]), .b_i(e2_q[i]), .p_o(sq2[i]));
    tcc_mul #(.AW(EW), .BW(EW)) u_s3 (.clk_i(clk_i), .a_i(e3_q[i]), .b_i(e3_q[i]), .p_o(sq3[i]));
  end

  tcc_dly #(.W(3 * EW), .N(3)) u_dly_e1 (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(e1_q), .q_o(e1_d));
  tcc_dly #(.W(3 * EW), .N(3)) u_dly_e2 (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(e2_q), .q_o(e2_d));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m_q[i] <= MW'($signed(pa[i])) - MW'($signed(pb[i]));
    end
    l_q[0] <= LW'($signed(sq1[0])) + LW'($signed(sq1[1])) + LW'($signed(sq1[2]));
    l_q[1] <= LW'($signed(sq2[0])) + LW'($signed(sq2[1])) + LW'($signed(sq2[2]));
    l_q[2] <= LW'($signed(sq3[0])) + LW'($signed(sq3[1])) + LW'($signed(sq3[2]));
  end

  // |m|^2, m x ab, ac x m
  logic [2:0][2*MW-1:0]    mmp;
  logic [2:0][MW+EW-1:0]   up, un, vp, vn;
  logic [MMW-1:0]          mm_q;
  logic [2:0][UW-1:0]      u_q, v_q;
  logic [2:0][LW-1:0]      l_d;
  logic [2:0][CW-1:0]      a_d;

  for (genvar i = 0; i < 3; i++) begin : g_mul_b
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    tcc_mul #(.AW(MW), .BW(MW)) u_mm (.clk_i(clk_i), .a_i(m_q[i]), .b_i(m_q[i]), .p_o(mmp[i]));
    tcc_mul #(.AW(MW), .BW(EW)) u_up (.clk_i(clk_i), .a_i(m_q[J]), .b_i(e1_d[K]), .p_o(up[i]));
    tcc_mul #(.AW(MW), .BW(EW)) u_un (.clk_i(clk_i), .a_i(m_q[K]), .b_i(e1_d[J]), .p_o(un[i]));
    tcc_mul #(.AW(MW), .BW(EW)) u_vp (.clk_i(clk_i), .a_i(m_q[K]), .b_i(e2_d[J]), .p_o(vp[i]));
    tcc_mul #(.AW(MW), .BW(EW)) u_vn (.clk_i(clk_i), .a_i(m_q[J]), .b_i(e2_d[K]), .p_o(vn[i]));
  end

  tcc_dly #(.W(3 * LW), .N(3)) u_dly_l (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(l_q), .q_o(l_d));
  tcc_dly #(.W(3 * CW), .N(6)) u_dly_a (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(a_q), .q_o(a_d));

  always_ff @(posedge clk_i) begin
    mm_q <= MMW'($signed(mmp[0])) + MMW'($signed(mmp[1])) + MMW'($signed(mmp[2]));
    for (int i = 0; i < 3; i++) begin
      u_q[i] <= UW'($signed(up[i])) - UW'($signed(un[i]));
      v_q[i] <= UW'($signed(vp[i])) - UW'($signed(vn[i]));
    end
  end

  // center numerators and l1*l2
  logic [2:0][UW+LW-1:0]     ul, vl;
  logic [2:0][CW+MMW:0]      ad;
  logic [2*LW-1:0]           l12p, l12_q;
  logic [2:0][NW-1:0]        numc_q;
  logic [LW-1:0]             l3_d;
  logic [MMW:0]              den2;

  assign den2 = {mm_q, 1'b0};

  for (genvar i = 0; i < 3; i++) begin : g_mul_c
    tcc_mul #(.AW(UW), .BW(LW)) u_ul (.clk_i(clk_i), .a_i(u_q[i]), .b_i(l_d[1]), .p_o(ul[i]));
    tcc_mul #(.AW(UW), .BW(LW)) u_vl (.clk_i(clk_i), .a_i(v_q[i]), .b_i(l_d[0]), .p_o(vl[i]));
    tcc_mul #(.AW(CW), .BW(MMW + 1)) u_ad (.clk_i(clk_i), .a_i(a_d[i]), .b_i(den2), .p_o(ad[i]));
  end

  tcc_mul #(.AW(LW), .BW(LW)) u_l12 (.clk_i(clk_i), .a_i(l_d[0]), .b_i(l_d[1]), .p_o(l12p));
  tcc_dly #(.W(LW), .N(3)) u_dly_l3 (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(l_d[2]), .q_o(l3_d));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      numc_q[i] <= NW'($signed(ul[i])) + NW'($signed(vl[i])) + NW'($signed(ad[i]));
    end
    l12_q <= l12p;
  end

  // radius numerator and alignment
  logic [3*LW-1:0]    l123;
  logic [2:0][NW-1:0] numc_d;
  logic [MMW-1:0]     mm_d;
  logic               vld_d;

  tcc_mul #(.AW(2 * LW), .BW(LW)) u_l123 (
    .clk_i (clk_i),
    .a_i   (l12_q),
    .b_i   (l3_d),
    .p_o   (l123)
  );

  tcc_dly #(.W(3 * NW), .N(2)) u_dly_n (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(numc_q), .q_o(numc_d));
  tcc_dly #(.W(MMW), .N(5)) u_dly_mm (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(mm_q), .q_o(mm_d));
  tcc_dly #(.W(1), .N(11)) u_dly_v (.clk_i(clk_i), .rst_ni(rst_ni), .d_i(vld0_q), .q_o(vld_d));

  // divider operands
  logic [2:0][NW-1:0]  nmag;
  logic [2:0][RWC-1:0] xc_q;
  logic [2:0]          sc_q;
  logic [DCW-1:0]      dc_q;
  logic [RWR-1:0]      xr_q;
  logic [DRW-1:0]      dr_q;
  logic [1:0]          tag_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = numc_d[i][NW-1] ? -numc_d[i] : numc_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= {vld_d, mm_d == '0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      xc_q[i] <= RWC'(nmag[i]) << (CSH_N + 1);
      sc_q[i] <= numc_d[i][NW-1];
    end
    dc_q <= DCW'(mm_d) << (1 + CSH_D);
    xr_q <= RWR'(l123) << (RSH_N + 1);
    dr_q <= DRW'(mm_d) << (2 + RSH_D);
  end

  // divider chains
  logic [2:0][QB:0] qc;
  logic [2:0]       sc;
  logic [QB:0]      qr;
  logic [1:0]       tagr;

  for (genvar i = 0; i < 3; i++) begin : g_div_c
    tcc_div #(.RW(RWC), .DW(DCW), .QB(QB), .TW(1)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .x_i    (xc_q[i]),
      .d_i    (dc_q),
      .tag_i  (sc_q[i]),
      .q_o    (qc[i]),
      .tag_o  (sc[i])
    );
  end

  tcc_div #(.RW(RWR), .DW(DRW), .QB(QB), .TW(2)) u_div_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (xr_q),
    .d_i    (dr_q),
    .tag_i  (tag_q),
    .q_o    (qr),
    .tag_o  (tagr)
  );

  // rounding and saturation
  logic [2:0][QB-1:0] cmag;
  logic [2:0]         csat;
  logic [2:0][OW-1:0] cval;
  logic [QB-1:0]      rmag;
  logic               rsat;
  tcc_pkg::res_t      res_d, res_q;
  logic               done_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = QB'(({1'b0, qc[i][QB-1:0]} + (QB+1)'(1)) >> 1);
      csat[i] = qc[i][QB] ||
                (sc[i] ? (cmag[i] > QB'(tcc_pkg::SAT_NEG)) : (cmag[i] > QB'(tcc_pkg::SAT_POS)));
      if (tagr[0]) begin
        cval[i] = '0;
      end else if (csat[i]) begin
        cval[i] = sc[i] ? tcc_pkg::SAT_NEG : tcc_pkg::SAT_POS;
      end else begin
        cval[i] = sc[i] ? -cmag[i][OW-1:0] : cmag[i][OW-1:0];
      end
    end
    rmag = QB'(({1'b0, qr[QB-1:0]} + (QB+1)'(1)) >> 1);
    rsat = qr[QB] || (rmag > QB'(tcc_pkg::SAT_U));
    res_d.center_x       = cval[0];
    res_d.center_y       = cval[1];
    res_d.center_z       = cval[2];
    res_d.radius_squared = tagr[0] ? '0 : (rsat ? tcc_pkg::SAT_U : rmag[OW-1:0]);
    res_d.degenerate     = tagr[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tagr[1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("request did not complete at fixed latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("done strobe without matching request");

  a_degenerate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.degenerate) |-> (res_o.center_x == '0 && res_o.center_y == '0 &&
      res_o.center_z == '0 && res_o.radius_squared == '0))
    else $error("degenerate result with nonzero fields");

endmodule
